// ===== hdl/ts_pes_audio_packetizer_defines.svh =====
// Assertion macros shared by the packetizer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef TS_PES_AUDIO_PACKETIZER_DEFINES_SVH
`define TS_PES_AUDIO_PACKETIZER_DEFINES_SVH

`define TPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("packetizer check failed");

`define TPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("packetizer check failed");

`endif

// ===== hdl/tpa_pkg.sv =====
// Types, constants and control structs of the transport stream packetizer.
// No dependencies; used by tpa_ctrl, tpa_datapath and the top level.
package tpa_pkg;

	localparam int LENGTH_BITS = 24;

	localparam logic [7:0] PACKET_BYTES = 8'd188;
	localparam logic [7:0] TS_HDR_BYTES = 8'd4;
	localparam logic [7:0] PES_HDR_BYTES = 8'd14;
	localparam logic [7:0] CAP_FIRST = PACKET_BYTES - TS_HDR_BYTES - PES_HDR_BYTES;
	localparam logic [7:0] CAP_NEXT = PACKET_BYTES - TS_HDR_BYTES;
	localparam logic [7:0] SYNC_BYTE = 8'h47;
	localparam logic [7:0] STREAM_ID = 8'hC0;
	localparam logic [7:0] PES_FLAGS = 8'h80;
	localparam logic [7:0] PES_HDR_LEN = 8'h05;
	localparam logic [7:0] FILL_BYTE = 8'hFF;
	localparam logic [12:0] PID_RESET = 13'd256;
	localparam logic [15:0] PES_LEN_MAX = 16'hFFFF;
	localparam logic [7:0] PES_LEN_EXTRA = 8'd8;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic frame_start;
		logic [23:0] frame_bytes;
		logic [32:0] pts_value;
	} in_item_t;

	typedef struct packed {
		logic [63:0] word_data;
		logic [3:0] byte_count;
		logic packet_end;
		logic frame_end;
	} out_item_t;

	typedef enum logic [1:0] {
		SRC_INPUT,
		SRC_HEADER,
		SRC_SAVED
	} push_src_t;

	typedef struct packed {
		logic take_frame;
		logic save_byte;
		logic open_pkt;
		logic first;
		logic push;
		push_src_t src;
		logic dec_frame;
		logic [7:0] hdr_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic push_ok;
		logic fbl_zero;
		logic pbl_zero;
		logic [7:0] hdr_len;
	} dp_sts_t;

endpackage

// ===== hdl/tpa_datapath.sv =====
// Packetizer datapath: frame and packet counters, header byte mux, word packer
// and output register. Depends on tpa_pkg and the assertion macro header.
`include "ts_pes_audio_packetizer_defines.svh"

module tpa_datapath (
	input logic clk,
	input logic arst_n,
	input tpa_pkg::in_item_t in_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [12:0] cfg_data,
	output logic out_valid,
	input logic out_stall,
	output tpa_pkg::out_item_t out_data,
	input tpa_pkg::dp_cmd_t cmd,
	output tpa_pkg::dp_sts_t sts
);
	import tpa_pkg::*;

	logic [12:0] pid_q;
	logic [3:0] cc_q;
	logic [LENGTH_BITS-1:0] fbl_q;
	logic [7:0] pbl_q;
	logic [63:0] buf_q;
	logic [3:0] fill_q;
	logic [32:0] pts_q;
	logic [7:0] saved_q;
	logic [7:0] stuff_q;
	logic [15:0] pes_len_q;
	logic [7:0] hdr_len_q;
	logic first_q;
	logic out_valid_q;
	out_item_t out_q;

	logic [7:0] cap;
	logic [7:0] len;
	logic [7:0] stuff_nx;
	logic [LENGTH_BITS:0] pes_sum;
	logic [7:0] idx_j;
	logic [7:0] idx_k;
	logic [7:0] hdr_byte;
	logic [7:0] push_byte;
	logic complete_pend;
	logic done;
	logic frame_last;
	logic [63:0] buf_nx;

	assign cfg_ready = 1'b1;

	always_comb begin
		cap = cmd.first ? CAP_FIRST : CAP_NEXT;
		len = (fbl_q < LENGTH_BITS'(cap)) ? fbl_q[7:0] : cap;
		stuff_nx = cap - len;
		pes_sum = {1'b0, fbl_q} + (LENGTH_BITS+1)'(PES_LEN_EXTRA);
	end

	always_comb begin
		idx_j = cmd.hdr_idx - TS_HDR_BYTES;
		idx_k = idx_j - stuff_q;
		hdr_byte = 8'h00;
		if (cmd.hdr_idx < TS_HDR_BYTES) begin
			case (cmd.hdr_idx[1:0])
				2'd0: hdr_byte = SYNC_BYTE;
				2'd1: hdr_byte = {1'b0, first_q, 1'b0, pid_q[12:8]};
				2'd2: hdr_byte = pid_q[7:0];
				2'd3: hdr_byte = {2'b00, stuff_q != 8'd0, 1'b1, cc_q};
				default: hdr_byte = 8'h00;
			endcase
		end else if (idx_j < stuff_q) begin
			if (idx_j == 8'd0) begin
				hdr_byte = stuff_q - 8'd1;
			end else if (idx_j == 8'd1) begin
				hdr_byte = 8'h00;
			end else begin
				hdr_byte = FILL_BYTE;
			end
		end else begin
			case (idx_k)
				8'd0: hdr_byte = 8'h00;
				8'd1: hdr_byte = 8'h00;
				8'd2: hdr_byte = 8'h01;
				8'd3: hdr_byte = STREAM_ID;
				8'd4: hdr_byte = pes_len_q[15:8];
				8'd5: hdr_byte = pes_len_q[7:0];
				8'd6: hdr_byte = PES_FLAGS;
				8'd7: hdr_byte = PES_FLAGS;
				8'd8: hdr_byte = PES_HDR_LEN;
				8'd9: hdr_byte = {4'b0010, pts_q[32:30], 1'b1};
				8'd10: hdr_byte = pts_q[29:22];
				8'd11: hdr_byte = {pts_q[21:15], 1'b1};
				8'd12: hdr_byte = pts_q[14:7];
				8'd13: hdr_byte = {pts_q[6:0], 1'b1};
				default: hdr_byte = 8'h00;
			endcase
		end
	end

	always_comb begin
		case (cmd.src)
			SRC_INPUT: push_byte = in_data.payload_byte;
			SRC_HEADER: push_byte = hdr_byte;
			SRC_SAVED: push_byte = saved_q;
			default: push_byte = 8'h00;
		endcase
		done = (pbl_q <= 8'd1);
		complete_pend = (fill_q[2:0] == 3'd7) || done;
		frame_last = cmd.dec_frame ? (fbl_q == LENGTH_BITS'(1)) : (fbl_q == '0);
		buf_nx = buf_q | ({56'b0, push_byte} << {~fill_q[2:0], 3'b000});
	end

	always_comb begin
		sts.push_ok = !(complete_pend && out_valid_q && out_stall);
		sts.fbl_zero = (fbl_q == '0);
		sts.pbl_zero = (pbl_q == 8'd0);
		sts.hdr_len = hdr_len_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pid_q <= PID_RESET;
		end else if (cfg_valid && cfg_ready) begin
			pid_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= 4'd0;
			fbl_q <= '0;
			pbl_q <= 8'd0;
			buf_q <= 64'd0;
			fill_q <= 4'd0;
			pts_q <= 33'd0;
			stuff_q <= 8'd0;
			pes_len_q <= 16'd0;
			hdr_len_q <= 8'd0;
			first_q <= 1'b0;
		end else begin
			if (cmd.take_frame) begin
				fbl_q <= in_data.frame_bytes[LENGTH_BITS-1:0];
				pts_q <= in_data.pts_value;
				buf_q <= 64'd0;
				fill_q <= 4'd0;
				pbl_q <= 8'd0;
			end
			if (cmd.open_pkt) begin
				cc_q <= cc_q + 4'd1;
				pbl_q <= PACKET_BYTES;
				stuff_q <= stuff_nx;
				first_q <= cmd.first;
				hdr_len_q <= TS_HDR_BYTES + stuff_nx + (cmd.first ? PES_HDR_BYTES : 8'd0);
				pes_len_q <= (pes_sum > (LENGTH_BITS+1)'(PES_LEN_MAX)) ? 16'd0 : pes_sum[15:0];
			end
			if (cmd.dec_frame) begin
				fbl_q <= fbl_q - LENGTH_BITS'(1);
			end
			if (cmd.push) begin
				if (pbl_q != 8'd0) begin
					pbl_q <= pbl_q - 8'd1;
				end
				if (complete_pend) begin
					buf_q <= 64'd0;
					fill_q <= 4'd0;
				end else begin
					buf_q <= buf_nx;
					fill_q <= fill_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saved_q <= 8'd0;
		end else if (cmd.save_byte) begin
			saved_q <= in_data.payload_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else if (cmd.push && complete_pend) begin
			out_valid_q <= 1'b1;
			out_q.word_data <= buf_nx;
			out_q.byte_count <= fill_q + 4'd1;
			out_q.packet_end <= done;
			out_q.frame_end <= done && frame_last;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`TPA_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.push && complete_pend && out_valid_q, !out_stall)
	`TPA_ASSERT_IMP(a_count_range, clk, arst_n, out_valid_q, out_q.byte_count >= 4'd1 && out_q.byte_count <= 4'd8)
	`TPA_ASSERT_IMP(a_pkt_tail, clk, arst_n, out_valid_q && out_q.packet_end, out_q.byte_count == 4'd4)
	`TPA_ASSERT_IMP(a_frame_in_pkt, clk, arst_n, out_valid_q && out_q.frame_end, out_q.packet_end)
	`TPA_ASSERT_NXT(a_open_full, clk, arst_n, cmd.open_pkt, pbl_q == PACKET_BYTES && fill_q == 4'd0)

endmodule

// ===== hdl/tpa_ctrl.sv =====
// Packetizer controller: accepts input items and sequences packet opening,
// header bytes and the held payload byte. Depends on tpa_pkg.
module tpa_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input tpa_pkg::in_item_t in_data,
	output tpa_pkg::dp_cmd_t cmd,
	input tpa_pkg::dp_sts_t sts
);
	import tpa_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_OPEN,
		ST_HDR,
		ST_PAY
	} state_t;

	state_t state_q;
	logic first_q;
	logic [7:0] idx_q;
	logic accept;
	logic len_nonzero;

	always_comb begin
		in_stall = (state_q != ST_IDLE) || !sts.push_ok;
		accept = in_valid && !in_stall;
		len_nonzero = |in_data.frame_bytes[LENGTH_BITS-1:0];
	end

	always_comb begin
		cmd = '0;
		cmd.src = SRC_INPUT;
		cmd.hdr_idx = idx_q;
		cmd.first = first_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_data.frame_start) begin
						cmd.take_frame = 1'b1;
						cmd.save_byte = 1'b1;
					end else if (!sts.fbl_zero) begin
						if (sts.pbl_zero) begin
							cmd.save_byte = 1'b1;
						end else begin
							cmd.push = 1'b1;
							cmd.dec_frame = 1'b1;
						end
					end
				end
			end
			ST_OPEN: begin
				cmd.open_pkt = 1'b1;
			end
			ST_HDR: begin
				cmd.push = sts.push_ok;
				cmd.src = SRC_HEADER;
			end
			ST_PAY: begin
				cmd.push = sts.push_ok;
				cmd.src = SRC_SAVED;
				cmd.dec_frame = sts.push_ok;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			first_q <= 1'b0;
			idx_q <= 8'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_data.frame_start) begin
							if (len_nonzero) begin
								first_q <= 1'b1;
								state_q <= ST_OPEN;
							end
						end else if (!sts.fbl_zero && sts.pbl_zero) begin
							first_q <= 1'b0;
							state_q <= ST_OPEN;
						end
					end
				end
				ST_OPEN: begin
					idx_q <= 8'd0;
					state_q <= ST_HDR;
				end
				ST_HDR: begin
					if (sts.push_ok) begin
						if (idx_q == sts.hdr_len - 8'd1) begin
							state_q <= ST_PAY;
						end else begin
							idx_q <= idx_q + 8'd1;
						end
					end
				end
				ST_PAY: begin
					if (sts.push_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/ts_pes_audio_packetizer.sv =====
// Channel  | direction | handshake             | payload
// in       | input     | in_valid / in_stall   | tpa_pkg::in_item_t in_data
// out      | output    | out_valid / out_stall | tpa_pkg::out_item_t out_data
// cfg      | input     | cfg_valid / cfg_ready | cfg_data, stream PID
// A payload byte inside an open packet is pushed straight into the byte packer.
// A byte that opens a packet passes ST_OPEN, ST_HDR for the H header bytes (4 to 187)
// and ST_PAY; the byte packer takes one header byte per cycle unless stalled.
// Reset is asynchronous; afterwards the PID is 256 and no frame is open.
// A full word waits in the output register; the packer stalls only when it
// completes another word while that register is still held.
// Top level of the transport stream packetizer. Depends on tpa_pkg,
// tpa_ctrl and tpa_datapath.
module ts_pes_audio_packetizer (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input tpa_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output tpa_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [12:0] cfg_data
);
	import tpa_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	tpa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.cmd(cmd),
		.sts(sts)
	);

	tpa_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cmd(cmd),
		.sts(sts)
	);

endmodule

// ===== dv/tpa_stream_checker.sv =====
// Stream checker for the transport stream packetizer: rebuilds the expected
// transport words from every accepted input item and compares the output channel.
// Depends on tpa_pkg only.
module tpa_stream_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input tpa_pkg::in_item_t in_data,
	input logic out_valid,
	input logic out_stall,
	input tpa_pkg::out_item_t out_data,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [12:0] cfg_data,
	output int errors,
	output int pending,
	output int words_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import tpa_pkg::*;

	localparam logic [7:0] UNIT_START = 8'h40;
	localparam logic [7:0] AFC_PAYLOAD = 8'h10;
	localparam logic [7:0] AFC_STUFFED = 8'h30;
	localparam logic [7:0] AF_NO_FLAGS = 8'h00;
	localparam logic [7:0] PTS_PREFIX = 8'h20;
	localparam logic [7:0] START_CODE_ZERO = 8'h00;
	localparam logic [7:0] START_CODE_ONE = 8'h01;
	localparam logic [23:0] LEN_MASK = 24'((64'd1 << LENGTH_BITS) - 64'd1);

	logic [12:0] pid;
	logic [3:0] cc;
	logic [23:0] frame_left;
	logic [7:0] pkt_left;
	logic [63:0] wbuf;
	logic [3:0] wfill;
	logic [32:0] pts_hold;
	out_item_t words_due[$];
	out_item_t want;

	task automatic note_fault(input string msg);
		$display("MISMATCH at %0t ns: %s", $realtime, msg);
		errors++;
	endtask

	task automatic pack_byte(input logic [7:0] b);
		out_item_t w;
		logic done;
		wbuf = wbuf | (64'(b) << ((7 - wfill[2:0]) * 8));
		wfill = wfill + 4'd1;
		if (pkt_left != 8'd0)
			pkt_left = pkt_left - 8'd1;
		done = (pkt_left == 8'd0);
		if (wfill >= 4'd8 || done) begin
			w.word_data = wbuf;
			w.byte_count = wfill;
			w.packet_end = done;
			w.frame_end = done && (frame_left == 24'd0);
			words_due.push_back(w);
			wbuf = '0;
			wfill = '0;
		end
	endtask

	task automatic open_packet(input logic first);
		logic [7:0] cap;
		logic [7:0] stuff;
		logic [23:0] len;
		logic [31:0] pes_len;
		cap = first ? CAP_FIRST : CAP_NEXT;
		len = (frame_left < 24'(cap)) ? frame_left : 24'(cap);
		stuff = cap - len[7:0];
		cc = cc + 4'd1;
		pkt_left = PACKET_BYTES;
		pack_byte(SYNC_BYTE);
		pack_byte((first ? UNIT_START : 8'h00) | {3'b000, pid[12:8]});
		pack_byte(pid[7:0]);
		pack_byte((stuff != 8'd0 ? AFC_STUFFED : AFC_PAYLOAD) | {4'h0, cc});
		if (stuff != 8'd0) begin
			pack_byte(stuff - 8'd1);
			if (stuff >= 8'd2) begin
				pack_byte(AF_NO_FLAGS);
				for (int i = 2; i < int'(stuff); i++)
					pack_byte(FILL_BYTE);
			end
		end
		if (first) begin
			pes_len = 32'(frame_left) + 32'(PES_LEN_EXTRA);
			if (pes_len > 32'(PES_LEN_MAX))
				pes_len = '0;
			pack_byte(START_CODE_ZERO);
			pack_byte(START_CODE_ZERO);
			pack_byte(START_CODE_ONE);
			pack_byte(STREAM_ID);
			pack_byte(pes_len[15:8]);
			pack_byte(pes_len[7:0]);
			pack_byte(PES_FLAGS);
			pack_byte(PES_FLAGS);
			pack_byte(PES_HDR_LEN);
			pack_byte(PTS_PREFIX | {4'h0, pts_hold[32:30], 1'b1});
			pack_byte(pts_hold[29:22]);
			pack_byte({pts_hold[21:15], 1'b1});
			pack_byte(pts_hold[14:7]);
			pack_byte({pts_hold[6:0], 1'b1});
		end
	endtask

	task automatic packetize(input in_item_t it);
		logic first;
		first = 1'b0;
		if (it.frame_start) begin
			wbuf = '0;
			wfill = '0;
			pkt_left = '0;
			frame_left = it.frame_bytes & LEN_MASK;
			pts_hold = it.pts_value;
			if (frame_left == 24'd0)
				return;
			first = 1'b1;
		end
		if (frame_left == 24'd0)
			return;
		if (first || pkt_left == 8'd0)
			open_packet(first);
		frame_left = frame_left - 24'd1;
		pack_byte(it.payload_byte);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pid = PID_RESET;
			cc = '0;
			frame_left = '0;
			pkt_left = '0;
			wbuf = '0;
			wfill = '0;
			pts_hold = '0;
			words_due.delete();
			errors = 0;
			pending = 0;
			words_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				pid = cfg_data;
			if (out_valid && !out_stall) begin
				words_seen++;
				if (words_due.size() == 0) begin
					note_fault($sformatf("unexpected word %h", out_data.word_data));
				end else begin
					want = words_due[0];
					words_due.delete(0);
					if (out_data.word_data !== want.word_data)
						note_fault($sformatf("word_data %h, want %h",
							out_data.word_data, want.word_data));
					if (out_data.byte_count !== want.byte_count)
						note_fault($sformatf("byte_count %0d, want %0d",
							out_data.byte_count, want.byte_count));
					if (out_data.packet_end !== want.packet_end)
						note_fault($sformatf("packet_end %b, want %b",
							out_data.packet_end, want.packet_end));
					if (out_data.frame_end !== want.frame_end)
						note_fault($sformatf("frame_end %b, want %b",
							out_data.frame_end, want.frame_end));
				end
			end
			if (in_valid && !in_stall)
				packetize(in_data);
			pending = words_due.size();
		end
	end

endmodule

// ===== dv/tb_ts_pes_audio_packetizer.sv =====
// Testbench top for the transport stream packetizer: drives directed and random
// audio frames, PID writes and output backpressure, and reports the verdict.
// Depends on tpa_pkg, ts_pes_audio_packetizer and tpa_stream_checker.
module tb_ts_pes_audio_packetizer;
	timeunit 1ns;
	timeprecision 1ps;
	import tpa_pkg::*;

	localparam int IDLE_CYCLES = 200;
	localparam int LONG_HOLD = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS = 30;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [12:0] cfg_data = '0;

	logic hold_req = 1'b0;
	logic calm = 1'b0;
	bit gaps_on = 1'b1;
	int errors;
	int pending;
	int words_seen;
	int items_sent = 0;
	int useful_items = 0;
	int frames_sent = 0;
	int pid_writes = 0;
	int quiet_cycles = 0;

	ts_pes_audio_packetizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	tpa_stream_checker checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending),
		.words_seen(words_seen)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no channel activity for %0d cycles", WATCHDOG_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		bit held;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(0, 20)) @(posedge clk);
			end
		end
	end

	function automatic logic [32:0] rand_pts();
		return {1'($urandom), 32'($urandom)};
	endfunction

	task automatic send_item(input in_item_t it);
		in_data <= it;
		in_valid <= 1'b1;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
		items_sent++;
		if (gaps_on && !calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic send_stray();
		in_item_t it;
		it.payload_byte = 8'($urandom);
		it.frame_start = 1'b0;
		it.frame_bytes = 24'($urandom);
		it.pts_value = rand_pts();
		send_item(it);
	endtask

	task automatic send_frame(input logic [23:0] declared, input int sent,
			input logic [32:0] pts, input logic [7:0] lead);
		in_item_t it;
		int count;
		count = (sent > 0) ? sent : 1;
		for (int i = 0; i < count; i++) begin
			it.payload_byte = (i == 0) ? lead : 8'($urandom);
			it.frame_start = (i == 0);
			it.frame_bytes = (i == 0) ? declared : 24'($urandom);
			it.pts_value = (i == 0) ? pts : rand_pts();
			send_item(it);
		end
		useful_items += count;
		frames_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_pid(input logic [12:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		pid_writes++;
	endtask

	task automatic run_frames(input int target);
		int pick;
		int start;
		int len;
		start = useful_items;
		while (useful_items - start < target) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				len = $urandom_range(1, 16);
				send_frame(24'(len), len, rand_pts(), 8'($urandom));
			end else if (pick < 77) begin
				send_frame(24'($urandom), $urandom_range(1, 3), rand_pts(), 8'($urandom));
			end else if (pick < 85) begin
				len = int'(CAP_FIRST) - $urandom_range(0, 3);
				send_frame(24'(len), $urandom_range(1, 3), rand_pts(), 8'($urandom));
			end else if (pick < 92) begin
				send_frame(24'd0, 0, rand_pts(), 8'($urandom));
			end else begin
				send_stray();
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_stray();
		send_frame(24'd1, 1, '1, 8'hFF);
		send_frame(24'd1, 1, '0, 8'h00);
		send_frame(24'(CAP_FIRST - 8'd1), 2, rand_pts(), 8'($urandom));
		send_frame(24'(CAP_FIRST - 8'd2), 1, rand_pts(), 8'($urandom));
		send_frame(24'hFFFFFF, 2, rand_pts(), 8'($urandom));
		send_frame(24'(PES_LEN_MAX - PES_LEN_EXTRA), 1, rand_pts(), 8'($urandom));
		send_frame(24'(PES_LEN_MAX - PES_LEN_EXTRA) + 24'd1, 1, rand_pts(), 8'($urandom));
		send_frame(24'd5, 3, rand_pts(), 8'($urandom));
		send_frame(24'd0, 0, rand_pts(), 8'($urandom));
		send_stray();
		send_frame(24'd3, 3, rand_pts(), 8'($urandom));
		wait_drained();

		write_pid('0);
		hold_req <= 1'b1;
		run_frames(PHASE_ITEMS);
		wait_drained();

		write_pid('1);
		run_frames(PHASE_ITEMS);
		wait_drained();

		write_pid(13'($urandom_range(1, 8190)));
		calm <= 1'b1;
		run_frames(PHASE_ITEMS);
		wait_drained();

		$display("Run covered %0d input items in %0d frames under %0d PID settings,",
			items_sent, frames_sent, pid_writes + 1);
		$display("%0d words compared; stray bytes, empty starts, restarts, stuffing, PES overflow.",
			words_seen);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== ts_pes_audio_packetizer.f =====
+incdir+hdl
hdl/tpa_pkg.sv
hdl/tpa_datapath.sv
hdl/tpa_ctrl.sv
hdl/ts_pes_audio_packetizer.sv
dv/tpa_stream_checker.sv
dv/tb_ts_pes_audio_packetizer.sv
